// File: sv/obrb_pkg.sv
`default_nettype none
package obrb_pkg;

  // Field and storage widths
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned PTR_W   = 8;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned RAM_DEPTH = 256;

  // Ring length limits and reset value of buffer_size
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = 9'd256;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // Operation codes
  typedef enum logic [2:0] {
    K_PUSH       = 3'd0,
    K_POP        = 3'd1,
    K_PEEK_FRONT = 3'd2,
    K_PEEK_REAR  = 3'd3,
    K_DROP       = 3'd4,
    K_SET_LEN    = 3'd5,
    K_RESET      = 3'd6
  } kind_t;

  // Result transaction as held between controller and top level
  typedef struct packed {
    logic              done;
    logic              rd_hit;
    logic              valid_res;
    logic              overflow;
    logic [PTR_W-1:0]  moved;
    logic [PTR_W-1:0]  fill_level;
  } res_t;

endpackage
`default_nettype wire

// File: sv/obrb_ram.sv
`default_nettype none
module obrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  q
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    q <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/obrb_ctrl.sv
`default_nettype none
module obrb_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [2:0]                    kind,
  input  wire logic [obrb_pkg::DATA_W-1:0]   data_byte,
  input  wire logic [7:0]                    amount,
  input  wire logic                          cfg_we,
  input  wire logic [obrb_pkg::SIZE_W-1:0]   cfg_data,
  output      logic                          ram_we,
  output      logic [obrb_pkg::PTR_W-1:0]    ram_waddr,
  output      logic [obrb_pkg::DATA_W-1:0]   ram_wdata,
  output      logic [obrb_pkg::PTR_W-1:0]    ram_raddr,
  output      obrb_pkg::res_t                res
);

  localparam int unsigned PW = obrb_pkg::PTR_W;
  localparam int unsigned SW = obrb_pkg::SIZE_W;

  logic [SW-1:0] buffer_size;
  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [SW-1:0] n;
  logic [SW-1:0] n_m1;
  logic [PW-1:0] fill;
  logic [PW-1:0] rd_pos;
  logic [SW-1:0] rear_off;
  logic [PW-1:0] k_drop;
  logic [PW-1:0] k_len;
  logic          hit;
  logic          is_read;
  obrb_pkg::res_t res_next;
  obrb_pkg::kind_t op;

  // a + b modulo n, with a < n and b < n
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                             input logic [SW-1:0] b,
                                             input logic [SW-1:0] len);
    logic [SW:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= {1'b0, len}) begin
      s = s - {1'b0, len};
    end
    return s[PW-1:0];
  endfunction

  // Bytes held between head and tail
  function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] h,
                                            input logic [PW-1:0] t,
                                            input logic [SW-1:0] len);
    logic [SW-1:0] f;
    if (t >= h) begin
      f = {1'b0, t} - {1'b0, h};
    end else begin
      f = len + {1'b0, t} - {1'b0, h};
    end
    return f[PW-1:0];
  endfunction

  assign op = obrb_pkg::kind_t'(kind);

  // Clamp the ring length in use
  always_comb begin
    if (buffer_size < obrb_pkg::SIZE_MIN) begin
      n = obrb_pkg::SIZE_MIN;
    end else if (buffer_size > obrb_pkg::SIZE_MAX) begin
      n = obrb_pkg::SIZE_MAX;
    end else begin
      n = buffer_size;
    end
  end

  assign n_m1     = n - 9'd1;
  assign fill     = fill_of(head, tail, n);
  assign hit      = amount < fill;
  assign rear_off = n_m1 - {1'b0, amount};
  assign k_drop   = hit ? amount : fill;
  assign k_len    = ({1'b0, amount} < n_m1) ? amount : n_m1[PW-1:0];

  // Decode the operation: pointer updates, RAM access, result fields
  always_comb begin
    head_next = head;
    tail_next = tail;
    rd_pos    = head;
    is_read   = 1'b0;
    ram_we    = 1'b0;
    res_next  = '0;
    unique case (op)
      obrb_pkg::K_PUSH: begin
        if ({1'b0, fill} >= n_m1) begin
          head_next         = wrap_add(head, 9'd1, n);
          res_next.overflow = 1'b1;
        end
        ram_we    = accept;
        tail_next = wrap_add(tail, 9'd1, n);
      end
      obrb_pkg::K_POP: begin
        if (fill != '0) begin
          is_read         = 1'b1;
          res_next.moved  = 8'd1;
          head_next       = wrap_add(head, 9'd1, n);
        end
      end
      obrb_pkg::K_PEEK_FRONT: begin
        rd_pos  = wrap_add(head, {1'b0, amount}, n);
        is_read = hit;
      end
      obrb_pkg::K_PEEK_REAR: begin
        rd_pos  = wrap_add(tail, rear_off, n);
        is_read = hit;
      end
      obrb_pkg::K_DROP: begin
        head_next      = wrap_add(head, {1'b0, k_drop}, n);
        res_next.moved = k_drop;
      end
      obrb_pkg::K_SET_LEN: begin
        tail_next = wrap_add(head, {1'b0, k_len}, n);
      end
      obrb_pkg::K_RESET: begin
        head_next = '0;
        tail_next = '0;
      end
      default: begin
      end
    endcase
    res_next.done       = accept;
    res_next.rd_hit     = accept & is_read;
    res_next.valid_res  = is_read;
    res_next.fill_level = fill_of(head_next, tail_next, n);
  end

  assign ram_waddr = tail;
  assign ram_wdata = data_byte;
  assign ram_raddr = rd_pos;

  // Hold ring length and pointers; a size write empties the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= obrb_pkg::SIZE_RESET;
      head        <= '0;
      tail        <= '0;
    end else if (cfg_we) begin
      buffer_size <= cfg_data;
      head        <= '0;
      tail        <= '0;
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  // Result strobe and read-hit flag every cycle; payload on each taken operation
  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else begin
      res.done   <= res_next.done;
      res.rd_hit <= res_next.rd_hit;
      if (accept) begin
        res.valid_res  <= res_next.valid_res;
        res.overflow   <= res_next.overflow;
        res.moved      <= res_next.moved;
        res.fill_level <= res_next.fill_level;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/overwriting_byte_ring_buffer_top.sv
// Overwriting byte ring buffer. Issue one operation by raising start with
// kind, data_byte and amount; the block takes one operation every clock and
// busy stays low. The result transaction appears on the cycle right after the
// operation is taken, marked by done for exactly one cycle, and cannot be
// held off: capture it when done is high. Pops and peeks read the 256-byte
// store through its registered read port, which sets when the result appears.
// A push into a full ring discards the oldest byte and reports overflow.
// Write buffer_size through cfg_valid/cfg_data (cfg_ready is always high) only
// while no operation is in flight; every write empties the ring. Sizes below
// 2 act as 2 and above 256 act as 256. Bytes exposed by a set-length that were
// never pushed read back as unknown data.
`default_nettype none
module overwriting_byte_ring_buffer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output      logic       busy,
  input  wire logic [2:0] kind,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] amount,
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [8:0] cfg_data,
  output      logic       done,
  output      logic [7:0] data_out,
  output      logic       valid_res,
  output      logic       overflow,
  output      logic [7:0] moved,
  output      logic [7:0] fill_level
);

  logic           accept;
  logic           cfg_we;
  logic           ram_we;
  logic [7:0]     ram_waddr;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_raddr;
  logic [7:0]     ram_q;
  obrb_pkg::res_t res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  obrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .data_byte (data_byte),
    .amount    (amount),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  obrb_ram #(
    .WIDTH (obrb_pkg::DATA_W),
    .DEPTH (obrb_pkg::RAM_DEPTH),
    .ADDR_W(obrb_pkg::PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .q     (ram_q)
  );

  // Drive the result transaction
  assign done       = res.done;
  assign data_out   = res.rd_hit ? ram_q : 8'd0;
  assign valid_res  = res.valid_res;
  assign overflow   = res.overflow;
  assign moved      = res.moved;
  assign fill_level = res.fill_level;

  // Every taken operation yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("missing result after accepted operation");

  // Read data only leaves the block with a result
  a_quiet_data: assert property (@(posedge clk) disable iff (rst)
    !done |-> data_out == 8'd0)
    else $error("data_out active without result");

  // An overwrite leaves the ring full, never empty
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> fill_level != 8'd0 && moved == 8'd0 && !valid_res)
    else $error("overflow result inconsistent");

endmodule
`default_nettype wire

// File: tb/obrb_checker.sv
`timescale 1ns / 100ps
module obrb_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] kind,
  input  logic [7:0] data_byte,
  input  logic [7:0] amount,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [8:0] cfg_data,
  input  logic       done,
  input  logic [7:0] data_out,
  input  logic       valid_res,
  input  logic       overflow,
  input  logic [7:0] moved,
  input  logic [7:0] fill_level,
  output int         fail_count,
  output int         results_due
);

  typedef struct packed {
    logic [obrb_pkg::DATA_W-1:0] data_out;
    logic                        valid_res;
    logic                        overflow;
    logic [obrb_pkg::PTR_W-1:0]  moved;
    logic [obrb_pkg::PTR_W-1:0]  fill_level;
  } ring_result_t;

  // Shadow copy of the ring
  logic [obrb_pkg::DATA_W-1:0] ring_mem [obrb_pkg::RAM_DEPTH];
  int unsigned                 rd_ptr;
  int unsigned                 wr_ptr;
  logic [obrb_pkg::SIZE_W-1:0] size_reg;

  ring_result_t expected_results [$];

  // Effective ring length after clamping the size register
  function automatic int unsigned ring_len();
    int unsigned n;
    n = size_reg;
    if (n < obrb_pkg::SIZE_MIN) n = obrb_pkg::SIZE_MIN;
    if (n > obrb_pkg::SIZE_MAX) n = obrb_pkg::SIZE_MAX;
    return n;
  endfunction

  function automatic int unsigned occupancy(int unsigned n);
    if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
    return n + wr_ptr - rd_ptr;
  endfunction

  // Apply one operation to the shadow ring and return its result transaction
  function automatic ring_result_t predict_ring_op(logic [2:0] op, logic [7:0] din,
                                                   logic [7:0] amt);
    ring_result_t r;
    int unsigned  n;
    int unsigned  fill;
    int unsigned  k;
    r = '0;
    n = ring_len();
    rd_ptr = rd_ptr % n;
    wr_ptr = wr_ptr % n;
    fill = occupancy(n);
    case (op)
      obrb_pkg::K_PUSH: begin
        // full ring: discard the oldest byte first
        if (fill >= n - 1) begin
          rd_ptr = (rd_ptr + 1) % n;
          r.overflow = 1'b1;
        end
        ring_mem[wr_ptr] = din;
        wr_ptr = (wr_ptr + 1) % n;
      end
      obrb_pkg::K_POP: begin
        if (fill > 0) begin
          r.data_out = ring_mem[rd_ptr];
          r.valid_res = 1'b1;
          r.moved = 8'd1;
          rd_ptr = (rd_ptr + 1) % n;
        end
      end
      obrb_pkg::K_PEEK_FRONT: begin
        if (amt < fill) begin
          r.data_out = ring_mem[(rd_ptr + amt) % n];
          r.valid_res = 1'b1;
        end
      end
      obrb_pkg::K_PEEK_REAR: begin
        // newest byte sits one slot before the write pointer
        if (amt < fill) begin
          r.data_out = ring_mem[(wr_ptr + n - 1 - amt) % n];
          r.valid_res = 1'b1;
        end
      end
      obrb_pkg::K_DROP: begin
        k = (amt < fill) ? amt : fill;
        rd_ptr = (rd_ptr + k) % n;
        r.moved = 8'(k);
      end
      obrb_pkg::K_SET_LEN: begin
        k = (amt < n - 1) ? amt : n - 1;
        wr_ptr = (rd_ptr + k) % n;
      end
      obrb_pkg::K_RESET: begin
        rd_ptr = 0;
        wr_ptr = 0;
      end
      default: ;
    endcase
    r.fill_level = 8'(occupancy(n));
    return r;
  endfunction

  // Report one field that differs; returns 1 on a mismatch
  function automatic int field_check(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v === want_v) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    ring_result_t want;
    int           bad;
    if (rst) begin
      foreach (ring_mem[j]) ring_mem[j] = '0;
      rd_ptr = 0;
      wr_ptr = 0;
      size_reg = obrb_pkg::SIZE_RESET;
      expected_results.delete();
      results_due <= 0;
      fail_count <= 0;
    end else begin
      bad = 0;
      // Compare a result transaction with the oldest expectation
      if (done) begin
        if (expected_results.size() == 0) begin
          bad++;
          $display("%0t: result with none expected, actual data_out %0d fill_level %0d",
                   $time, data_out, fill_level);
        end else begin
          want = expected_results.pop_front();
          bad += field_check("data_out", want.data_out, data_out);
          bad += field_check("valid_res", 8'(want.valid_res), 8'(valid_res));
          bad += field_check("overflow", 8'(want.overflow), 8'(overflow));
          bad += field_check("moved", want.moved, moved);
          bad += field_check("fill_level", want.fill_level, fill_level);
        end
      end
      // Size write empties the ring
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_data;
        rd_ptr = 0;
        wr_ptr = 0;
      end
      // Predict each accepted transaction
      if (start && !busy)
        expected_results.push_back(predict_ring_op(kind, data_byte, amount));
      results_due <= expected_results.size();
      fail_count <= fail_count + bad;
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  localparam logic [2:0] K_UNUSED = 3'd7;
  localparam int         GAP_CAP  = 8;
  localparam int         PHASES   = 10;
  localparam int         PHASE_OPS = 117;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic [7:0] amount;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [8:0] cfg_data;
  logic       done;
  logic [7:0] data_out;
  logic       valid_res;
  logic       overflow;
  logic [7:0] moved;
  logic [7:0] fill_level;
  int         fail_count;
  int         results_due;

  int          idle_pct;
  int unsigned ring_span;

  always #2 clk = ~clk;

  overwriting_byte_ring_buffer_top uut (.*);

  obrb_checker chk (.*);

  // Hard stop if the run hangs
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Issue one transaction after a random gap, hold until accepted
  task automatic issue_op(logic [2:0] op, logic [7:0] din, logic [7:0] amt);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= op;
    data_byte <= din;
    amount <= amt;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_size(logic [8:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ring_span = (value < obrb_pkg::SIZE_MIN) ? obrb_pkg::SIZE_MIN :
                (value > obrb_pkg::SIZE_MAX) ? obrb_pkg::SIZE_MAX : value;
  endtask

  // Random operation, push-heavy so the ring fills and wraps
  task automatic random_op();
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  amt;
    pick = $urandom_range(99);
    if (pick < 38) op = obrb_pkg::K_PUSH;
    else if (pick < 52) op = obrb_pkg::K_POP;
    else if (pick < 64) op = obrb_pkg::K_PEEK_FRONT;
    else if (pick < 76) op = obrb_pkg::K_PEEK_REAR;
    else if (pick < 85) op = obrb_pkg::K_DROP;
    else if (pick < 94) op = obrb_pkg::K_SET_LEN;
    else if (pick < 97) op = obrb_pkg::K_RESET;
    else op = K_UNUSED;
    // offsets mostly within the ring length, sometimes anywhere
    if ($urandom_range(3) == 0) amt = 8'($urandom_range(255));
    else amt = 8'($urandom_range((ring_span > 255) ? 255 : ring_span));
    issue_op(op, 8'($urandom_range(255)), amt);
  endtask

  initial begin
    logic [8:0]  phase_sizes [PHASES];
    int unsigned p;
    int unsigned i;
    phase_sizes = '{9'd0, 9'd3, 9'd256, 9'd511, 9'd2, 9'd17, 9'd1, 9'd200, 9'd257, 9'd64};
    rst <= 1'b1;
    start <= 1'b0;
    kind <= obrb_pkg::K_PUSH;
    data_byte <= 8'h00;
    amount <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_data <= 9'd0;
    idle_pct = 7;
    ring_span = obrb_pkg::SIZE_MAX;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Write every store slot once so no later read meets an unwritten byte
    write_size(obrb_pkg::SIZE_MAX);
    repeat (obrb_pkg::RAM_DEPTH)
      issue_op(obrb_pkg::K_PUSH, 8'($urandom_range(255)), 8'($urandom_range(255)));

    // Directed corners on a four-byte ring
    write_size(9'd5);
    issue_op(obrb_pkg::K_POP, 8'h00, 8'h00);
    issue_op(obrb_pkg::K_PEEK_FRONT, 8'hFF, 8'h00);
    issue_op(obrb_pkg::K_PEEK_REAR, 8'h00, 8'hFF);
    issue_op(obrb_pkg::K_DROP, 8'h00, 8'h01);
    issue_op(obrb_pkg::K_PUSH, 8'h00, 8'h00);
    issue_op(obrb_pkg::K_PUSH, 8'hFF, 8'hFF);
    issue_op(obrb_pkg::K_PUSH, 8'hA5, 8'h00);
    issue_op(obrb_pkg::K_PUSH, 8'h5A, 8'h00);
    // ring full: overwrite the oldest byte
    issue_op(obrb_pkg::K_PUSH, 8'h3C, 8'h00);
    issue_op(obrb_pkg::K_PEEK_FRONT, 8'h00, 8'h00);
    issue_op(obrb_pkg::K_PEEK_FRONT, 8'h00, 8'h03);
    issue_op(obrb_pkg::K_PEEK_FRONT, 8'h00, 8'h04);
    issue_op(obrb_pkg::K_PEEK_REAR, 8'h00, 8'h00);
    issue_op(obrb_pkg::K_PEEK_REAR, 8'h00, 8'h03);
    issue_op(obrb_pkg::K_PEEK_REAR, 8'h00, 8'hFF);
    issue_op(obrb_pkg::K_POP, 8'h00, 8'h00);
    // drop and set length past what the ring holds
    issue_op(obrb_pkg::K_DROP, 8'h00, 8'hFF);
    issue_op(obrb_pkg::K_SET_LEN, 8'h00, 8'hFF);
    issue_op(obrb_pkg::K_PEEK_REAR, 8'h00, 8'h00);
    issue_op(obrb_pkg::K_RESET, 8'hFF, 8'hFF);
    issue_op(K_UNUSED, 8'hFF, 8'hFF);
    issue_op(obrb_pkg::K_SET_LEN, 8'h00, 8'h02);
    issue_op(obrb_pkg::K_POP, 8'h00, 8'h00);
    issue_op(obrb_pkg::K_DROP, 8'h00, 8'h00);

    // Random phases over several sizes; sender idling light, heavy, then none
    for (p = 0; p < PHASES; p++) begin
      if (p == 3) idle_pct = 60;
      else if (p == 6) idle_pct = 0;
      write_size(phase_sizes[p]);
      for (i = 0; i < PHASE_OPS; i++) begin
        if ($urandom_range(199) == 0) drain();
        random_op();
      end
    end

    // Wait out the last results, bounded
    start <= 1'b0;
    i = 0;
    while (results_due != 0 && i < 1000) begin
      @(posedge clk);
      i++;
    end
    repeat (4) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
